[src/qle_pkg.sv]
package qle_pkg;

  // table geometry
  localparam int NUM_STATES  = 256;
  localparam int NUM_ACTIONS = 4;
  localparam int ST_W        = $clog2(NUM_STATES);
  localparam int AC_W        = $clog2(NUM_ACTIONS);
  localparam int ADDR_W      = ST_W + AC_W;
  localparam int Q_DEPTH     = NUM_STATES * NUM_ACTIONS;

  // field widths
  localparam int Q_W         = 32;
  localparam int FRAC_W      = 16;
  localparam int LVL_W       = 17;
  localparam int IDX_W       = 8;
  localparam int ACT_W       = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 56;

  // fixed-point constants and register reset values
  localparam logic [LVL_W-1:0]  LEVEL_ONE     = 17'h10000;
  localparam logic [FRAC_W-1:0] ALPHA_RST     = 16'd6554;
  localparam logic [FRAC_W-1:0] GAMMA_RST     = 16'd58982;
  localparam logic [LVL_W-1:0]  INIT_EXPL_RST = 17'd65536;
  localparam logic [FRAC_W-1:0] DECAY_RST     = 16'd65208;
  localparam logic [LVL_W-1:0]  EXPL_MIN_RST  = 17'd655;

  // operation selector carried on tuser
  localparam logic OP_CHOOSE = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA     = 3'd0,
    REG_GAMMA     = 3'd1,
    REG_INIT_EXPL = 3'd2,
    REG_DECAY     = 3'd3,
    REG_EXPL_MIN  = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_NEXT,
    ST_READ_Q,
    ST_MUL_G,
    ST_DIFF,
    ST_MUL_A,
    ST_WRITE,
    ST_SCAN_ROW,
    ST_SCAN_WAIT,
    ST_RESULT
  } fsm_t;

  // step enables for the update arithmetic
  typedef struct packed {
    logic mul_g;
    logic diff;
    logic mul_a;
    logic wr;
  } arith_ctl_t;

endpackage

[src/qle_ram.sv]
module qle_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/qle_argmax.sv]
module qle_argmax (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         issue,
  input  logic [qle_pkg::AC_W-1:0]     issue_idx,
  input  logic [qle_pkg::Q_W-1:0]      rd_data,
  output logic signed [qle_pkg::Q_W-1:0] best_val,
  output logic [qle_pkg::AC_W-1:0]     best_idx
);

  // read data arrives the cycle after its address is issued
  logic                     vld_d;
  logic [qle_pkg::AC_W-1:0] idx_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d <= 1'b0;
    end else begin
      vld_d <= issue;
    end
    idx_d <= issue_idx;
  end

  // first entry of a row seeds the search; strictly greater keeps the first maximum
  always_ff @(posedge clk) begin
    if (vld_d && (idx_d == '0 || $signed(rd_data) > best_val)) begin
      best_val <= $signed(rd_data);
      best_idx <= idx_d;
    end
  end

endmodule

[src/qle_arith.sv]
module qle_arith (
  input  logic                                 clk,
  input  logic                                 rst,
  input  qle_pkg::arith_ctl_t                  ctl,
  input  logic [qle_pkg::FRAC_W-1:0]           alpha,
  input  logic [qle_pkg::FRAC_W-1:0]           gamma,
  input  logic [qle_pkg::FRAC_W-1:0]           decay,
  input  logic [qle_pkg::LVL_W-1:0]            expl_min,
  input  logic [qle_pkg::LVL_W-1:0]            lvl_init,
  input  logic                                 lvl_load,
  input  logic                                 done,
  input  logic signed [qle_pkg::Q_W-1:0]       reward,
  input  logic [qle_pkg::Q_W-1:0]              q_rd,
  input  logic signed [qle_pkg::Q_W-1:0]       max_val,
  output logic [qle_pkg::Q_W-1:0]              wr_data,
  output logic signed [qle_pkg::Q_W-1:0]       newq,
  output logic [qle_pkg::LVL_W-1:0]            level
);

  logic signed [qle_pkg::Q_W-1:0] q_reg;
  logic signed [48:0]             prod_g;
  logic signed [34:0]             diff;
  logic signed [51:0]             prod_a;
  logic signed [36:0]             sum;
  logic [qle_pkg::LVL_W-1:0]      lvl_tmp;
  logic [32:0]                    lvl_prod;

  // gamma*max, then reward + floor(gamma*max) - q, then alpha*diff
  always_ff @(posedge clk) begin
    if (ctl.mul_g) begin
      q_reg  <= $signed(q_rd);
      prod_g <= $signed({1'b0, gamma}) * max_val;
    end
    if (ctl.diff) begin
      diff <= 35'(reward) + 35'(prod_g >>> 16) - 35'(q_reg);
    end
    if (ctl.mul_a) begin
      prod_a <= $signed({1'b0, alpha}) * diff;
    end
    if (ctl.wr) begin
      newq <= $signed(wr_data);
    end
  end

  // new value saturated to the signed 32-bit range
  always_comb begin
    sum = 37'(q_reg) + 37'(prod_a >>> 16);
    if (sum[36:31] == 6'b000000 || sum[36:31] == 6'b111111) begin
      wr_data = sum[31:0];
    end else if (sum[36]) begin
      wr_data = 32'h8000_0000;
    end else begin
      wr_data = 32'h7FFF_FFFF;
    end
  end

  assign lvl_prod = 33'(lvl_tmp) * 33'(decay);

  // level: reload to 1.0 at the floor or at episode end, then decay above the floor
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= qle_pkg::INIT_EXPL_RST;
    end else if (lvl_load) begin
      level <= lvl_init;
    end else if (ctl.diff) begin
      if (lvl_tmp > expl_min) begin
        level <= lvl_prod[32:16];
      end else begin
        level <= lvl_tmp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_g) begin
      lvl_tmp <= (level <= expl_min || done) ? qle_pkg::LEVEL_ONE : level;
    end
  end

endmodule

[src/tabular_q_learning_engine.sv]
// Tabular Q-learning engine with epsilon-greedy choice. The Q-table (NUM_STATES rows of
// NUM_ACTIONS signed Q16.16 entries) sits in one single-port-write, one-read synchronous
// memory; one item is worked at a time and every table access goes through that memory.
// After reset a clearing pass writes zero to every entry, one entry a cycle, and the input
// is held off until all NUM_STATES*NUM_ACTIONS entries (1024 with the shipped sizes) are
// cleared; config writes are taken during that pass. An exploring choose goes straight
// to the result, a greedy choose first scans its row, and an update runs a scan of the
// next state's row, one read of the updated entry, the gamma multiply, the difference,
// the alpha multiply and the saturated write-back. The memory read port sets the scan
// length. Items are accepted while the previous result still waits in the output register.
// Config writes belong in idle periods only; writing initial_exploration also reloads
// the exploration level.
module tabular_q_learning_engine (
  input  logic                               clk,
  input  logic                               rst,
  // input requests
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // state_index[7:0], taken_action[9:8], reward[41:10], next_state_index[49:42],
  // random_fraction[65:50], random_pick[67:66], zero pad
  input  logic [qle_pkg::IN_TDATA_W-1:0]     s_tdata,
  // action: 0 choose, 1 update
  input  logic                               s_tuser,
  // episode_done
  input  logic                               s_tlast,
  // result requests
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // chosen_action[1:0], updated_q[33:2], exploration_level[50:34], zero pad
  output logic [qle_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // explored
  output logic                               m_tuser,
  // config write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [qle_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qle_pkg::CFG_DATA_W-1:0]     cfg_data
);

  qle_pkg::fsm_t                  state, state_next;
  logic [qle_pkg::AC_W-1:0]       cnt, cnt_next;
  logic [qle_pkg::ADDR_W-1:0]     clr_cnt;

  // config registers
  logic [qle_pkg::FRAC_W-1:0]     alpha, gamma, decay;
  logic [qle_pkg::LVL_W-1:0]      expl_min;
  logic                           cfg_we, lvl_load;

  // captured item
  logic                           op_reg, explore_reg, done_reg;
  logic [qle_pkg::ST_W-1:0]       st_reg, nst_reg;
  logic [qle_pkg::AC_W-1:0]       act_reg, pick_reg;
  logic signed [qle_pkg::Q_W-1:0] reward_reg;

  // input fields
  logic [qle_pkg::IDX_W-1:0]      in_state, in_next;
  logic [qle_pkg::ACT_W-1:0]      in_taken, in_pick;
  logic [qle_pkg::FRAC_W-1:0]     in_frac;
  logic                           accept, explore_now;

  // memory and datapath
  logic                           ram_we, issue;
  logic [qle_pkg::ADDR_W-1:0]     waddr, raddr;
  logic [qle_pkg::Q_W-1:0]        wdata, rdata, upd_data;
  logic signed [qle_pkg::Q_W-1:0] best_val, newq;
  logic [qle_pkg::AC_W-1:0]       best_idx;
  logic [qle_pkg::LVL_W-1:0]      level;
  qle_pkg::arith_ctl_t            ctl;
  logic                           load_out;

  // result register
  logic [qle_pkg::ACT_W-1:0]      out_chosen;
  logic                           out_explored;
  logic [qle_pkg::Q_W-1:0]        out_q;
  logic [qle_pkg::LVL_W-1:0]      out_level;

  assign in_state = s_tdata[7:0];
  assign in_taken = s_tdata[9:8];
  assign in_next  = s_tdata[49:42];
  assign in_frac  = s_tdata[65:50];
  assign in_pick  = s_tdata[67:66];

  assign s_tready    = (state == qle_pkg::ST_IDLE);
  assign accept      = s_tvalid && s_tready;
  // explore when the random fraction falls below the level
  assign explore_now = (s_tuser == qle_pkg::OP_CHOOSE) && ({1'b0, in_frac} < level);

  // config port never stalls
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign lvl_load  = cfg_we && (cfg_index == qle_pkg::REG_INIT_EXPL);

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha     <= qle_pkg::ALPHA_RST;
      gamma     <= qle_pkg::GAMMA_RST;
      decay     <= qle_pkg::DECAY_RST;
      expl_min  <= qle_pkg::EXPL_MIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        qle_pkg::REG_ALPHA:     alpha     <= cfg_data[qle_pkg::FRAC_W-1:0];
        qle_pkg::REG_GAMMA:     gamma     <= cfg_data[qle_pkg::FRAC_W-1:0];
        qle_pkg::REG_INIT_EXPL: ;  // goes straight into the exploration level
        qle_pkg::REG_DECAY:     decay     <= cfg_data[qle_pkg::FRAC_W-1:0];
        qle_pkg::REG_EXPL_MIN:  expl_min  <= cfg_data;
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // capture the item; states and actions wrap to the table size
  always_ff @(posedge clk) begin
    if (accept) begin
      op_reg      <= s_tuser;
      explore_reg <= explore_now;
      done_reg    <= s_tlast;
      st_reg      <= in_state[qle_pkg::ST_W-1:0];
      nst_reg     <= in_next[qle_pkg::ST_W-1:0];
      act_reg     <= in_taken[qle_pkg::AC_W-1:0];
      pick_reg    <= in_pick[qle_pkg::AC_W-1:0];
      reward_reg  <= $signed(s_tdata[41:10]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= qle_pkg::ST_CLEAR;
      cnt     <= '0;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == qle_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    issue      = 1'b0;
    raddr      = {st_reg, act_reg};
    ram_we     = 1'b0;
    waddr      = {st_reg, act_reg};
    wdata      = upd_data;
    ctl        = '0;
    load_out   = 1'b0;
    case (state)
      qle_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        waddr  = clr_cnt;
        wdata  = '0;
        if (clr_cnt == qle_pkg::ADDR_W'(qle_pkg::Q_DEPTH - 1)) begin
          state_next = qle_pkg::ST_IDLE;
        end
      end
      qle_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_next = '0;
          if (s_tuser == qle_pkg::OP_UPDATE) begin
            state_next = qle_pkg::ST_SCAN_NEXT;
          end else if (explore_now) begin
            state_next = qle_pkg::ST_RESULT;
          end else begin
            state_next = qle_pkg::ST_SCAN_ROW;
          end
        end
      end
      // walk the next state's row for its maximum
      qle_pkg::ST_SCAN_NEXT: begin
        issue    = 1'b1;
        raddr    = {nst_reg, cnt};
        cnt_next = cnt + 1'b1;
        if (cnt == qle_pkg::AC_W'(qle_pkg::NUM_ACTIONS - 1)) begin
          cnt_next   = '0;
          state_next = qle_pkg::ST_READ_Q;
        end
      end
      // fetch the entry being updated
      qle_pkg::ST_READ_Q: begin
        raddr      = {st_reg, act_reg};
        state_next = qle_pkg::ST_MUL_G;
      end
      qle_pkg::ST_MUL_G: begin
        ctl.mul_g  = 1'b1;
        state_next = qle_pkg::ST_DIFF;
      end
      qle_pkg::ST_DIFF: begin
        ctl.diff   = 1'b1;
        state_next = qle_pkg::ST_MUL_A;
      end
      qle_pkg::ST_MUL_A: begin
        ctl.mul_a  = 1'b1;
        state_next = qle_pkg::ST_WRITE;
      end
      qle_pkg::ST_WRITE: begin
        ctl.wr     = 1'b1;
        ram_we     = 1'b1;
        state_next = qle_pkg::ST_RESULT;
      end
      // walk the current row for the greedy pick
      qle_pkg::ST_SCAN_ROW: begin
        issue    = 1'b1;
        raddr    = {st_reg, cnt};
        cnt_next = cnt + 1'b1;
        if (cnt == qle_pkg::AC_W'(qle_pkg::NUM_ACTIONS - 1)) begin
          cnt_next   = '0;
          state_next = qle_pkg::ST_SCAN_WAIT;
        end
      end
      qle_pkg::ST_SCAN_WAIT: begin
        state_next = qle_pkg::ST_RESULT;
      end
      // hand off once the output register is free
      qle_pkg::ST_RESULT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = qle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = qle_pkg::ST_IDLE;
      end
    endcase
  end

  qle_ram #(
    .DEPTH (qle_pkg::Q_DEPTH),
    .WIDTH (qle_pkg::Q_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  qle_argmax u_argmax (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .issue_idx (cnt),
    .rd_data   (rdata),
    .best_val  (best_val),
    .best_idx  (best_idx)
  );

  qle_arith u_arith (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .alpha    (alpha),
    .gamma    (gamma),
    .decay    (decay),
    .expl_min (expl_min),
    .lvl_init (cfg_data),
    .lvl_load (lvl_load),
    .done     (done_reg),
    .reward   (reward_reg),
    .q_rd     (rdata),
    .max_val  (best_val),
    .wr_data  (upd_data),
    .newq     (newq),
    .level    (level)
  );

  // output register parts the result side from the input side
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_level <= level;
      if (op_reg == qle_pkg::OP_UPDATE) begin
        out_chosen   <= '0;
        out_explored <= 1'b0;
        out_q        <= newq;
      end else begin
        out_chosen   <= qle_pkg::ACT_W'(explore_reg ? pick_reg : best_idx);
        out_explored <= explore_reg;
        out_q        <= '0;
      end
    end
  end

  assign m_tdata = {5'b0, out_level, out_q, out_chosen};
  assign m_tuser = out_explored;

endmodule
